>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is ignored while reset is asserted
`define RSOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define RSOC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/rsoc_pkg.sv
// shared types and constants of the slope and occupancy classifier
package rsoc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int LIM_W      = (WIDTH_W > ADDR_W + 1) ? WIDTH_W : ADDR_W + 1;
    localparam int OCC_W      = 16;
    localparam int THR_W      = 15;
    localparam int ELEV_W     = 24;
    localparam int RISE_W     = 24;
    localparam int CLASS_W    = 2;
    localparam int COL_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // input tdata layout, lowest bit first
    localparam int S_OCC_LSB     = 0;
    localparam int S_OCC_OK_BIT  = S_OCC_LSB + OCC_W;
    localparam int S_ELEV_LSB    = S_OCC_OK_BIT + 1;
    localparam int S_ELEV_OK_BIT = S_ELEV_LSB + ELEV_W;
    localparam int S_FIELDS_W    = S_ELEV_OK_BIT + 1;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int M_CLASS_LSB = 0;
    localparam int M_COL_LSB   = M_CLASS_LSB + CLASS_W;
    localparam int M_FIELDS_W  = M_COL_LSB + COL_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic signed [OCC_W-1:0] OCC_ONE        = 16'sd16384;
    localparam logic [WIDTH_W-1:0]      WIDTH_RESET    = 11'd1024;
    localparam logic [THR_W-1:0]        THRESH_RESET   = 15'd8192;
    localparam logic [RISE_W-1:0]       RISE_RESET     = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_OCC_THRESHOLD = 2'd1,
        CFG_RISE_LIMIT    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OCC_BELOW   = 2'd0,
        OCC_ABOVE   = 2'd1,
        OCC_INVALID = 2'd2
    } t_occ_code;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_FREE    = 2'd0,
        CLASS_BLOCKED = 2'd1,
        CLASS_UNKNOWN = 2'd2
    } t_cell_class;

    typedef struct packed {
        logic                     ok;
        logic signed [ELEV_W-1:0] elev;
    } t_elev_word;

    typedef struct packed {
        t_occ_code  occ;
        t_elev_word ev;
    } t_cell_word;

    // row store access issued with each accepted cell
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] rd_next;
        logic              fwd;
    } t_mem_ctrl;

    typedef struct packed {
        logic left;
        logic right;
        logic up;
        logic down;
    } t_nbr_en;

endpackage

>>> src/rsoc_row_mem.sv
// upper and middle row stores with registered synchronous reads
module rsoc_row_mem import rsoc_pkg::*; (
    input  logic       i_clk,
    input  t_mem_ctrl  i_ctrl,
    input  t_elev_word i_up_wdata,
    input  t_cell_word i_mid_wdata,
    output t_elev_word o_up_rdata,
    output t_cell_word o_mid_rdata
);

    t_elev_word r_upper_mem [MAX_WIDTH];
    t_cell_word r_middle_mem [MAX_WIDTH];
    t_elev_word r_up_rdata;
    t_cell_word r_mid_rdata;

    // read-first: the up neighbour is the entry before this write
    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_up_rdata <= r_upper_mem[i_ctrl.addr];
            r_upper_mem[i_ctrl.addr] <= i_up_wdata;
        end
    end

    // read ahead one column; a single-column row rereads what is written now
    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            if (i_ctrl.fwd) begin
                r_mid_rdata <= i_mid_wdata;
            end else begin
                r_mid_rdata <= r_middle_mem[i_ctrl.rd_next];
            end
            r_middle_mem[i_ctrl.addr] <= i_mid_wdata;
        end
    end

    assign o_up_rdata  = r_up_rdata;
    assign o_mid_rdata = r_mid_rdata;

endmodule

>>> src/rsoc_classify.sv
// occupancy and four-neighbour slope decision for one centre cell
module rsoc_classify import rsoc_pkg::*; (
    input  t_cell_word        i_centre,
    input  t_elev_word        i_left,
    input  t_elev_word        i_right,
    input  t_elev_word        i_up,
    input  t_elev_word        i_down,
    input  t_nbr_en           i_nbr_en,
    input  logic [RISE_W-1:0] i_rise_limit,
    output t_cell_class       o_class
);

    function automatic logic too_steep(input t_elev_word nbr,
                                       input logic signed [ELEV_W-1:0] centre,
                                       input logic [RISE_W-1:0] limit);
        logic signed [ELEV_W:0] diff;
        logic [ELEV_W:0]        mag;
        diff = {nbr.elev[ELEV_W-1], nbr.elev} - {centre[ELEV_W-1], centre};
        mag  = diff[ELEV_W] ? (ELEV_W+1)'(-diff) : (ELEV_W+1)'(diff);
        return nbr.ok && (mag > (ELEV_W+1)'(limit));
    endfunction

    logic steep;
    logic occ_known;

    always_comb begin
        steep = (i_nbr_en.left  && too_steep(i_left,  i_centre.ev.elev, i_rise_limit))
             || (i_nbr_en.right && too_steep(i_right, i_centre.ev.elev, i_rise_limit))
             || (i_nbr_en.up    && too_steep(i_up,    i_centre.ev.elev, i_rise_limit))
             || (i_nbr_en.down  && too_steep(i_down,  i_centre.ev.elev, i_rise_limit));
        occ_known = (i_centre.occ == OCC_BELOW) || (i_centre.occ == OCC_ABOVE);
        if (!occ_known || !i_centre.ev.ok) begin
            o_class = CLASS_UNKNOWN;
        end else if (i_centre.occ == OCC_ABOVE || steep) begin
            o_class = CLASS_BLOCKED;
        end else begin
            o_class = CLASS_FREE;
        end
    end

endmodule

>>> src/raster_slope_occupancy_classifier_top.sv
// top level: cell packing, row store sequencing, classify stage and output register
// once the cell below is accepted, the cell above is classified and registered; one cell
// per cycle unless output stalls, each doing one read-modify-write of both row stores;
// the right neighbour is read one column ahead so no store needs a second read port
// reset (synchronous, active low) clears column count, row count, pipeline valids and
// config registers; row stores are not cleared and hold garbage until rows are written
module raster_slope_occupancy_classifier_top import rsoc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // occupancy[15:0], occupancy_ok[16], elevation[40:17], elevation_ok[41], zeros above
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // padding[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // cell_class[1:0], cell_column[11:2], zeros above
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // frame_last
    output logic                  o_m_axis_tlast
);

    logic [WIDTH_W-1:0] r_image_width;
    logic [THR_W-1:0]   r_occ_threshold;
    logic [RISE_W-1:0]  r_rise_limit;

    logic [ADDR_W-1:0] r_col;
    logic [1:0]        r_rows_seen;

    logic              r_s1_valid;
    logic              r_s1_produce;
    t_cell_word        r_s1_mid;
    t_elev_word        r_s1_left;
    t_elev_word        r_s1_down;
    t_nbr_en           r_s1_en;
    logic [ADDR_W-1:0] r_s1_col;
    logic              r_s1_last;

    logic              r_out_valid;
    t_cell_class       r_out_class;
    logic [COL_W-1:0]  r_out_col;
    logic              r_out_last;

    logic [LIM_W-1:0]  width_ext;
    logic [LIM_W-1:0]  eff_width;
    logic              last_col;
    logic              accept;
    logic              s1_move;
    logic              pad;
    logic signed [OCC_W-1:0] occ;
    logic              occ_ok;
    t_cell_word        new_word;
    t_cell_word        mid_cur;
    t_elev_word        up_rdata;
    t_mem_ctrl         mem_ctrl;
    t_cell_class       s1_class;
    logic [ADDR_W-1:0] n_col;
    logic [1:0]        n_rows_seen;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= WIDTH_RESET;
            r_occ_threshold <= THRESH_RESET;
            r_rise_limit    <= RISE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_OCC_THRESHOLD: r_occ_threshold <= i_cfg_wdata[THR_W-1:0];
                CFG_RISE_LIMIT:    r_rise_limit    <= i_cfg_wdata[RISE_W-1:0];
                default: ;
            endcase
        end
    end

    // row end detection on the clamped width
    always_comb begin
        width_ext = LIM_W'(r_image_width);
        if (width_ext == '0) begin
            eff_width = LIM_W'(1);
        end else if (width_ext > LIM_W'(MAX_WIDTH)) begin
            eff_width = LIM_W'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        last_col = (LIM_W'(r_col) + LIM_W'(1)) >= eff_width;
    end

    // incoming cell packing, threshold applied on the way into the store
    always_comb begin
        pad    = i_s_axis_tuser;
        occ    = i_s_axis_tdata[S_OCC_LSB +: OCC_W];
        occ_ok = i_s_axis_tdata[S_OCC_OK_BIT];
        if (pad) begin
            new_word.occ     = OCC_INVALID;
            new_word.ev.ok   = 1'b0;
            new_word.ev.elev = '0;
        end else begin
            if (!occ_ok || occ < 0 || occ > OCC_ONE) begin
                new_word.occ = OCC_INVALID;
            end else if ($unsigned(occ) >= OCC_W'(r_occ_threshold)) begin
                new_word.occ = OCC_ABOVE;
            end else begin
                new_word.occ = OCC_BELOW;
            end
            new_word.ev.ok   = i_s_axis_tdata[S_ELEV_OK_BIT];
            new_word.ev.elev = i_s_axis_tdata[S_ELEV_LSB +: ELEV_W];
        end
    end

    assign s1_move = r_s1_valid && (!r_s1_produce || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_move;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        mem_ctrl.we      = accept;
        mem_ctrl.addr    = r_col;
        mem_ctrl.rd_next = last_col ? '0 : ADDR_W'(r_col + 1'b1);
        mem_ctrl.fwd     = (mem_ctrl.rd_next == r_col);
    end

    rsoc_row_mem u_row_mem (
        .i_clk       (i_clk),
        .i_ctrl      (mem_ctrl),
        .i_up_wdata  (mid_cur.ev),
        .i_mid_wdata (new_word),
        .o_up_rdata  (up_rdata),
        .o_mid_rdata (mid_cur)
    );

    // column and row tracking
    always_comb begin
        n_col       = r_col;
        n_rows_seen = r_rows_seen;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                if (pad) begin
                    n_rows_seen = 2'd0;
                end else if (r_rows_seen != 2'd2) begin
                    n_rows_seen = r_rows_seen + 2'd1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_rows_seen <= 2'd0;
        end else begin
            r_col       <= n_col;
            r_rows_seen <= n_rows_seen;
        end
    end

    // classify stage: centre, left and down are captured here, up and right
    // come straight from the store read registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s1_produce <= 1'b0;
        end else if (accept) begin
            r_s1_valid   <= 1'b1;
            r_s1_produce <= (r_rows_seen != 2'd0);
        end else if (s1_move) begin
            r_s1_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mid      <= mid_cur;
            r_s1_left     <= r_s1_mid.ev;
            r_s1_down     <= new_word.ev;
            r_s1_en.left  <= (r_col != '0);
            r_s1_en.right <= !last_col;
            r_s1_en.up    <= (r_rows_seen == 2'd2);
            r_s1_en.down  <= !pad;
            r_s1_col      <= r_col;
            r_s1_last     <= pad && last_col;
        end
    end

    rsoc_classify u_classify (
        .i_centre     (r_s1_mid),
        .i_left       (r_s1_left),
        .i_right      (mid_cur.ev),
        .i_up         (up_rdata),
        .i_down       (r_s1_down),
        .i_nbr_en     (r_s1_en),
        .i_rise_limit (r_rise_limit),
        .o_class      (s1_class)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_produce) begin
            r_out_class <= s1_class;
            r_out_col   <= COL_W'(r_s1_col);
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_col, r_out_class});
    assign o_m_axis_tlast  = r_out_last;

endmodule

>>> src/rsoc_checker.sv
// port-level checker for the classifier top, attached by bind
`include "assert_macros.svh"

module rsoc_checker import rsoc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tlast
);

    logic                            out_stall;
    logic [M_TDATA_W:0]              out_word;
    logic [CLASS_W-1:0]              out_class;
    logic [M_TDATA_W-M_FIELDS_W-1:0] out_fill;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word  = {o_m_axis_tlast, o_m_axis_tdata};
    assign out_class = o_m_axis_tdata[M_CLASS_LSB +: CLASS_W];
    assign out_fill  = o_m_axis_tdata[M_TDATA_W-1:M_FIELDS_W];

    // a stalled result keeps its payload
    `RSOC_ASSERT(a_out_hold, out_stall |=> o_m_axis_tvalid && $stable(out_word), "result not held")

    // class code three is never produced
    `RSOC_ASSERT(a_class_code, o_m_axis_tvalid |-> out_class <= CLASS_UNKNOWN, "illegal cell class")

    // fill bits above the column stay zero
    `RSOC_ASSERT(a_fill_zero, o_m_axis_tvalid |-> out_fill == '0, "nonzero fill bits in result")

    // with the output register empty the input side never stalls
    `RSOC_ASSERT(a_ready_when_empty, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled while empty")

    // reset empties the output
    `RSOC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind raster_slope_occupancy_classifier_top rsoc_checker u_rsoc_checker (.*);

>>> bench/raster_slope_occupancy_classifier_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the raster slope and occupancy classifier: directed and random grids
module raster_slope_occupancy_classifier_top_tb;
    import rsoc_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int SETTLE_CYC = 8;
    localparam int ITEM_GOAL  = 1500;

    typedef struct {
        logic signed [OCC_W-1:0]  occ;
        logic                     occ_ok;
        logic signed [ELEV_W-1:0] elev;
        logic                     elev_ok;
        logic                     pad;
    } t_grid_cell;

    typedef struct packed {
        t_cell_class      cls;
        logic [COL_W-1:0] col;
        logic             last;
    } t_class_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // shadow of the block's registers and row stores
    logic [WIDTH_W-1:0] cfg_width  = WIDTH_RESET;
    logic [THR_W-1:0]   cfg_thresh = THRESH_RESET;
    logic [RISE_W-1:0]  cfg_rise   = RISE_RESET;
    t_cell_word         mid_row [MAX_WIDTH];
    t_elev_word         top_row [MAX_WIDTH];
    int                 col_pos   = 0;
    int                 rows_held = 0;

    t_class_result expected_class_q [$];
    int            fail_count       = 0;
    int            cells_sent       = 0;
    bit            src_idle_en      = 1'b1;
    bit            snk_idle_en      = 1'b1;
    int            sink_hold_cycles = 0;

    raster_slope_occupancy_classifier_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int row_width();
        if (cfg_width < 1) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic bit too_steep(t_elev_word nb, logic signed [ELEV_W-1:0] centre);
        longint d;
        if (!nb.ok) return 1'b0;
        d = longint'($signed(nb.elev)) - longint'(centre);
        if (d < 0) d = -d;
        return d > longint'(cfg_rise);
    endfunction

    // classify the cell one row above the incoming one, then shift the row stores
    function automatic void classify_cell(t_grid_cell c);
        int            w;
        int            col;
        bit            last_col;
        bit            steep;
        t_cell_word    nw;
        t_cell_word    mid;
        t_class_result res;
        w        = row_width();
        col      = col_pos;
        last_col = (col + 1 >= w);
        nw       = '0;
        nw.occ   = OCC_INVALID;
        if (!c.pad) begin
            if (c.occ_ok && c.occ >= 0 && int'(c.occ) <= int'(OCC_ONE))
                nw.occ = (int'(c.occ) >= int'(cfg_thresh)) ? OCC_ABOVE : OCC_BELOW;
            nw.ev.elev = c.elev;
            nw.ev.ok   = c.elev_ok;
        end
        if (rows_held != 0) begin
            mid      = mid_row[col];
            res.col  = col[COL_W-1:0];
            res.last = c.pad && last_col;
            if ((mid.occ != OCC_BELOW && mid.occ != OCC_ABOVE) || !mid.ev.ok) begin
                res.cls = CLASS_UNKNOWN;
            end else begin
                steep = 1'b0;
                // left neighbour was already shifted into the upper store this row
                if (col > 0)
                    steep |= too_steep(top_row[col - 1], mid.ev.elev);
                if (!last_col && col + 1 < MAX_WIDTH)
                    steep |= too_steep(mid_row[col + 1].ev, mid.ev.elev);
                if (rows_held >= 2)
                    steep |= too_steep(top_row[col], mid.ev.elev);
                if (!c.pad)
                    steep |= too_steep(nw.ev, mid.ev.elev);
                res.cls = (mid.occ == OCC_ABOVE || steep) ? CLASS_BLOCKED : CLASS_FREE;
            end
            expected_class_q.push_back(res);
        end
        top_row[col] = mid_row[col].ev;
        mid_row[col] = nw;
        if (last_col) begin
            col_pos = 0;
            if (c.pad)
                rows_held = 0;
            else if (rows_held < 2)
                rows_held++;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    function automatic int pick_pause(bit en);
        int r;
        if (!en) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0: return THR_W'(0);
            1: return THR_W'(16384);
            2: return 15'h7FFF;
            3: return THRESH_RESET;
            default: return THR_W'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic logic [RISE_W-1:0] pick_rise();
        case ($urandom_range(0, 9))
            0: return RISE_W'(0);
            1: return RISE_RESET;
            2: return RISE_W'($urandom_range(0, 24'hFFFFFF));
            default: return RISE_W'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic t_grid_cell cell_of(int occ, bit occ_ok, int elev, bit elev_ok, bit pad);
        t_grid_cell c;
        c.occ     = occ[OCC_W-1:0];
        c.occ_ok  = occ_ok;
        c.elev    = elev[ELEV_W-1:0];
        c.elev_ok = elev_ok;
        c.pad     = pad;
        return c;
    endfunction

    // elevation scattered around a base so that the rise limit sits inside the spread
    function automatic t_grid_cell rand_cell(int base, int span);
        t_grid_cell c;
        int         r;
        int         v;
        r = $urandom_range(0, 19);
        if (r == 0)
            c.occ = OCC_W'($urandom);
        else if (r == 1)
            c.occ = OCC_W'(int'(cfg_thresh) + int'($urandom_range(0, 2)) - 1);
        else
            c.occ = OCC_W'($urandom_range(0, 16384));
        c.occ_ok = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 19) == 0)
            v = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        else
            v = base + int'($urandom_range(0, span)) - span / 2;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        c.elev    = v[ELEV_W-1:0];
        c.elev_ok = ($urandom_range(0, 15) != 0);
        c.pad     = ($urandom_range(0, 39) == 0);
        return c;
    endfunction

    // called at a rising edge; returns at the edge of the transfer with valid still high
    task automatic send_cell(input t_grid_cell c);
        int                   gap;
        logic [S_TDATA_W-1:0] data;
        gap = pick_pause(src_idle_en);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        data = '0;
        data[S_OCC_LSB +: OCC_W]   = c.occ;
        data[S_OCC_OK_BIT]         = c.occ_ok;
        data[S_ELEV_LSB +: ELEV_W] = c.elev;
        data[S_ELEV_OK_BIT]        = c.elev_ok;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= c.pad;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        classify_cell(c);
        cells_sent++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_class_q.size() != 0) @(posedge i_clk);
        // items with no result may still be in flight
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [WIDTH_W-1:0] w, input logic [THR_W-1:0] thr,
                               input logic [RISE_W-1:0] rise);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_IMAGE_WIDTH;
        i_cfg_wdata <= CFG_DATA_W'(w);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_OCC_THRESHOLD;
        i_cfg_wdata <= CFG_DATA_W'(thr);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RISE_LIMIT;
        i_cfg_wdata <= rise;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_width  = w;
        cfg_thresh = thr;
        cfg_rise   = rise;
    endtask

    // grid rows at the current width, then one padding row to flush the bottom row
    task automatic send_frame(input int rows);
        int         w;
        int         base;
        int         span;
        t_grid_cell c;
        w    = row_width();
        base = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        span = (cfg_rise <= 1000) ? 3 * int'(cfg_rise) + 4 : 4000000;
        for (int r = 0; r < rows; r++)
            for (int k = 0; k < w; k++)
                send_cell(rand_cell(base, span));
        for (int k = 0; k < w; k++) begin
            c     = rand_cell(base, span);
            c.pad = 1'b1;
            send_cell(c);
        end
    endtask

    task automatic test_directed_cases();
        load_config(WIDTH_W'(4), THRESH_RESET, RISE_W'(100));
        // top row: occupancy around the threshold, nothing reported yet
        send_cell(cell_of(0, 1, 0, 1, 0));
        send_cell(cell_of(8191, 1, 0, 1, 0));
        send_cell(cell_of(8192, 1, 50, 1, 0));
        send_cell(cell_of(16384, 1, 0, 1, 0));
        // out of range and invalid occupancy, invalid elevation
        send_cell(cell_of(-1, 1, 0, 1, 0));
        send_cell(cell_of(16385, 1, 0, 1, 0));
        send_cell(cell_of(0, 0, 0, 1, 0));
        send_cell(cell_of(0, 1, 0, 0, 0));
        // elevation extremes and rises just over the limit
        send_cell(cell_of(32767, 1, 8388607, 1, 0));
        send_cell(cell_of(-32768, 1, -8388608, 1, 0));
        send_cell(cell_of(0, 1, 101, 1, 0));
        send_cell(cell_of(0, 1, -100, 1, 0));
        // padding mid-row only degrades, padding in the last column ends the frame
        send_cell(cell_of(0, 1, 0, 1, 1));
        send_cell(cell_of(0, 1, 0, 1, 0));
        send_cell(cell_of(100, 1, 200, 1, 0));
        send_cell(cell_of(0, 1, 0, 1, 1));
    endtask

    task automatic test_width_change_mid_row();
        t_grid_cell c;
        load_config(WIDTH_W'(5), THRESH_RESET, RISE_W'(1000));
        repeat (7) send_cell(rand_cell(0, 3004));
        load_config(WIDTH_W'(2), THRESH_RESET, RISE_W'(1000));
        // column 2 now closes the row
        send_cell(rand_cell(0, 3004));
        repeat (2) begin
            c     = rand_cell(0, 3004);
            c.pad = 1'b1;
            send_cell(c);
        end
    endtask

    task automatic test_width_extremes();
        t_grid_cell c;
        load_config(WIDTH_W'(0), pick_threshold(), pick_rise());
        send_frame(4);
        load_config(WIDTH_W'(1), pick_threshold(), pick_rise());
        send_frame(4);
        // an oversized width clamps, so the row closes at the last store column
        load_config(11'h7FF, pick_threshold(), pick_rise());
        repeat (MAX_WIDTH) send_cell(rand_cell(0, 3004));
        // a single-column padding row then reports column zero and ends the frame
        load_config(WIDTH_W'(1), pick_threshold(), pick_rise());
        c     = rand_cell(0, 3004);
        c.pad = 1'b1;
        send_cell(c);
    endtask

    task automatic test_limit_extremes();
        load_config(WIDTH_W'(5), THR_W'(0), RISE_W'(0));
        send_frame(3);
        load_config(WIDTH_W'(5), THR_W'(16384), RISE_RESET);
        send_frame(3);
        load_config(WIDTH_W'(5), 15'h7FFF, RISE_W'(1));
        send_frame(3);
        load_config(WIDTH_W'(5), THR_W'(16385), 24'h800000);
        send_frame(3);
    endtask

    task automatic test_output_backpressure();
        load_config(WIDTH_W'(16), pick_threshold(), pick_rise());
        src_idle_en      = 1'b0;
        sink_hold_cycles = 300;
        send_frame(6);
        src_idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int r;
        int w;
        while (cells_sent < ITEM_GOAL) begin
            r = $urandom_range(0, 39);
            w = (r < 4) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            load_config(WIDTH_W'(w), pick_threshold(), pick_rise());
            src_idle_en = ($urandom_range(0, 5) != 0);
            snk_idle_en = src_idle_en;
            send_frame($urandom_range(1, 6));
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    initial begin : result_sink
        int               stall;
        t_class_result    want;
        t_cell_class      got_cls;
        logic [COL_W-1:0] got_col;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got_cls = t_cell_class'(o_m_axis_tdata[M_CLASS_LSB +: CLASS_W]);
                got_col = o_m_axis_tdata[M_COL_LSB +: COL_W];
                if (expected_class_q.size() == 0) begin
                    $error("unexpected transfer: cell_class %0d cell_column %0d",
                           got_cls, got_col);
                    fail_count++;
                end else begin
                    want = expected_class_q.pop_front();
                    if (got_cls !== want.cls) begin
                        $error("cell_class: expected %0d, got %0d", want.cls, got_cls);
                        fail_count++;
                    end
                    if (got_col !== want.col) begin
                        $error("cell_column: expected %0d, got %0d", want.col, got_col);
                        fail_count++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("frame_last: expected %0d, got %0d", want.last, o_m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (sink_hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end else if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_pause(snk_idle_en);
            end
        end
    end

    initial begin : watchdog
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : run_tests
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_width_change_mid_row();
        test_width_extremes();
        test_limit_extremes();
        test_output_backpressure();
        test_random_frames();
        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
